@@ src/dsts_pkg.sv @@
// shared types and constants for the drag start tree sequencer
// no dependencies
package dsts_pkg;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 16;

    localparam logic [2:0] CFG_EXIT_HOLD  = 3'd0;
    localparam logic [2:0] CFG_PRESTAGE   = 3'd1;
    localparam logic [2:0] CFG_TREE_STEP  = 3'd2;
    localparam logic [2:0] CFG_FAILED     = 3'd3;
    localparam logic [2:0] CFG_GREEN_NORUN = 3'd4;
    localparam logic [2:0] CFG_LAUNCH_SPD = 3'd5;

    localparam logic [1:0] CD_YELLOW1 = 2'd3;
    localparam logic [1:0] CD_YELLOW2 = 2'd2;
    localparam logic [1:0] CD_YELLOW3 = 2'd1;
    localparam logic [1:0] CD_NONE    = 2'd0;

    typedef struct packed {
        logic [15:0] exit_hold_ms;
        logic [15:0] prestage_hold_ms;
        logic [15:0] tree_step_ms;
        logic [15:0] failed_launch_ms;
        logic [15:0] green_no_run_ms;
        logic [11:0] launch_min_speed;
    } t_cfg;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        has_fix;
        logic [11:0] speed_tenths;
        logic        select_held;
        logic        side_button_held;
        logic        button_pressed;
        logic        timer_staged;
        logic        run_active;
        logic [15:0] run_total;
        logic        start_session;
    } t_item;

    typedef struct packed {
        logic [3:0] stage;
        logic       exit_session;
        logic       consumed_button;
        logic       green_pulse;
        logic       run_start_pulse;
        logic [1:0] countdown;
        logic       foul;
        logic       strip_active;
    } t_res;

endpackage

@@ src/dsts_regs.sv @@
// configuration register file of the start tree sequencer
// depends on dsts_pkg
module dsts_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    output dsts_pkg::t_cfg      o_cfg
);
    import dsts_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.exit_hold_ms     <= 16'd2000;
            r_cfg.prestage_hold_ms <= 16'd500;
            r_cfg.tree_step_ms     <= 16'd500;
            r_cfg.failed_launch_ms <= 16'd3000;
            r_cfg.green_no_run_ms  <= 16'd2000;
            r_cfg.launch_min_speed <= 12'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EXIT_HOLD:   r_cfg.exit_hold_ms     <= i_cfg_data;
                CFG_PRESTAGE:    r_cfg.prestage_hold_ms <= i_cfg_data;
                CFG_TREE_STEP:   r_cfg.tree_step_ms     <= i_cfg_data;
                CFG_FAILED:      r_cfg.failed_launch_ms <= i_cfg_data;
                CFG_GREEN_NORUN: r_cfg.green_no_run_ms  <= i_cfg_data;
                CFG_LAUNCH_SPD:  r_cfg.launch_min_speed <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/dsts_fsm.sv @@
// stage state machine: session state and next-stage logic for one sample
// depends on dsts_pkg
module dsts_fsm (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  dsts_pkg::t_item i_item,
    input  dsts_pkg::t_cfg  i_cfg,
    output dsts_pkg::t_res  o_res
);
    import dsts_pkg::*;

    typedef enum logic [3:0] {
        ST_AWAIT   = 4'd0,
        ST_WAIT    = 4'd1,
        ST_PRE     = 4'd2,
        ST_Y1      = 4'd3,
        ST_Y2      = 4'd4,
        ST_Y3      = 4'd5,
        ST_GREEN   = 4'd6,
        ST_RUN     = 4'd7,
        ST_RESULTS = 4'd8,
        ST_RED     = 4'd9,
        ST_FAILED  = 4'd10,
        ST_ABORT   = 4'd11
    } t_stage;

    t_stage      r_stage, n_stage, e_stage;
    logic [31:0] r_entered, n_entered, e_entered;
    logic [31:0] r_green, n_green, e_green;
    logic [31:0] r_hold_start, n_hold_start, e_hold_start;
    logic        r_track, n_track, e_track;
    logic        r_rel, n_rel, e_rel;
    logic        r_prev, n_prev, e_prev;
    logic [15:0] r_last, n_last, e_last;

    logic        moving;
    logic        ex, used, gp, rp;
    logic [31:0] t_stage_el, t_green_el, t_hold_el;
    logic [1:0]  cd;

    // session start clears state before the sample is processed
    always_comb begin
        e_stage      = i_item.start_session ? ST_AWAIT : r_stage;
        e_entered    = i_item.start_session ? i_item.now_ms : r_entered;
        e_green      = i_item.start_session ? 32'd0 : r_green;
        e_hold_start = i_item.start_session ? 32'd0 : r_hold_start;
        e_track      = i_item.start_session ? 1'b0 : r_track;
        e_rel        = i_item.start_session ? 1'b0 : r_rel;
        e_prev       = i_item.start_session ? 1'b0 : r_prev;
        e_last       = i_item.start_session ? 16'd0 : r_last;
    end

    assign moving     = i_item.has_fix && (i_item.speed_tenths >= i_cfg.launch_min_speed);
    assign t_stage_el = i_item.now_ms - e_entered;
    assign t_green_el = i_item.now_ms - e_green;
    assign t_hold_el  = i_item.now_ms - e_hold_start;

    always_comb begin
        n_stage      = e_stage;
        n_entered    = e_entered;
        n_green      = e_green;
        n_hold_start = e_hold_start;
        n_track      = e_track;
        n_rel        = e_rel | ~i_item.select_held;
        n_last       = e_last;
        n_prev       = i_item.run_active;
        ex   = 1'b0;
        used = 1'b0;
        gp   = 1'b0;
        rp   = 1'b0;

        // select-hold exit
        if (e_stage != ST_RUN && n_rel && i_item.select_held && !i_item.side_button_held) begin
            if (!e_track) begin
                n_track      = 1'b1;
                n_hold_start = i_item.now_ms;
            end else if (t_hold_el >= {16'd0, i_cfg.exit_hold_ms}) begin
                ex = 1'b1;
            end
        end else begin
            n_track = 1'b0;
        end

        if (!ex) begin
            case (e_stage)
                ST_AWAIT: begin
                    if (i_item.button_pressed) begin
                        used      = 1'b1;
                        n_stage   = ST_WAIT;
                        n_entered = i_item.now_ms;
                    end
                end
                ST_WAIT: begin
                    if (i_item.timer_staged) begin
                        n_stage   = ST_PRE;
                        n_entered = i_item.now_ms;
                    end
                end
                ST_PRE: begin
                    if (!i_item.timer_staged) begin
                        n_stage   = ST_WAIT;
                        n_entered = i_item.now_ms;
                    end else if (t_stage_el >= {16'd0, i_cfg.prestage_hold_ms}) begin
                        n_stage   = ST_Y1;
                        n_entered = i_item.now_ms;
                    end
                end
                ST_Y1, ST_Y2, ST_Y3: begin
                    if (moving) begin
                        n_stage   = ST_RED;
                        n_entered = i_item.now_ms;
                    end else if (!i_item.timer_staged || !i_item.has_fix) begin
                        n_stage   = ST_WAIT;
                        n_entered = i_item.now_ms;
                    end else if (t_stage_el >= {16'd0, i_cfg.tree_step_ms}) begin
                        n_entered = i_item.now_ms;
                        if (e_stage == ST_Y1) begin
                            n_stage = ST_Y2;
                        end else if (e_stage == ST_Y2) begin
                            n_stage = ST_Y3;
                        end else begin
                            n_stage = ST_GREEN;
                            n_green = i_item.now_ms;
                            gp      = 1'b1;
                        end
                    end
                end
                ST_GREEN: begin
                    if (i_item.run_active && !e_prev) begin
                        rp        = 1'b1;
                        n_last    = i_item.run_total;
                        n_stage   = ST_RUN;
                        n_entered = i_item.now_ms;
                    end else if (!moving && t_green_el >= {16'd0, i_cfg.failed_launch_ms}) begin
                        n_stage   = ST_FAILED;
                        n_entered = i_item.now_ms;
                    end else if (moving && !i_item.run_active
                                 && t_green_el >= {16'd0, i_cfg.green_no_run_ms}) begin
                        n_stage   = ST_ABORT;
                        n_entered = i_item.now_ms;
                    end
                end
                ST_RUN: begin
                    if (i_item.run_total > e_last) begin
                        n_stage   = ST_RESULTS;
                        n_entered = i_item.now_ms;
                    end else if (!i_item.run_active && e_prev) begin
                        n_stage   = ST_ABORT;
                        n_entered = i_item.now_ms;
                    end
                end
                ST_RESULTS, ST_RED, ST_FAILED, ST_ABORT: begin
                    if (i_item.button_pressed) begin
                        used      = 1'b1;
                        n_stage   = ST_WAIT;
                        n_entered = i_item.now_ms;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (n_stage)
            ST_Y1:   cd = CD_YELLOW1;
            ST_Y2:   cd = CD_YELLOW2;
            ST_Y3:   cd = CD_YELLOW3;
            default: cd = CD_NONE;
        endcase
    end

    assign o_res.stage           = n_stage;
    assign o_res.exit_session    = ex;
    assign o_res.consumed_button = used;
    assign o_res.green_pulse     = gp;
    assign o_res.run_start_pulse = rp;
    assign o_res.countdown       = cd;
    assign o_res.foul            = (n_stage == ST_RED) || (n_stage == ST_FAILED)
                                   || (n_stage == ST_ABORT);
    assign o_res.strip_active    = (n_stage != ST_RUN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage      <= ST_AWAIT;
            r_entered    <= 32'd0;
            r_green      <= 32'd0;
            r_hold_start <= 32'd0;
            r_track      <= 1'b0;
            r_rel        <= 1'b0;
            r_prev       <= 1'b0;
            r_last       <= 16'd0;
        end else if (i_en) begin
            r_stage      <= n_stage;
            r_entered    <= n_entered;
            r_green      <= n_green;
            r_hold_start <= n_hold_start;
            r_track      <= n_track;
            r_rel        <= n_rel;
            r_prev       <= n_prev;
            r_last       <= n_last;
        end
    end

    a_green_enters_green: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && o_res.green_pulse |=> r_stage == ST_GREEN && r_green == $past(i_item.now_ms))
        else $error("green pulse without green stage");

    a_run_start_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && o_res.run_start_pulse |=> r_stage == ST_RUN
                                          && r_last == $past(i_item.run_total))
        else $error("run start did not latch run count");

    a_exit_holds_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && o_res.exit_session && !i_item.start_session |=> r_stage == $past(r_stage))
        else $error("stage moved on exit");

    a_idle_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_stage) && $stable(r_entered) && $stable(r_track))
        else $error("state changed without a sample");

endmodule

@@ src/drag_start_tree_sequencer_core.sv @@
// Drag start tree sequencer: takes one timestamped sample word per cycle and gives one
// result word per sample, held in the input register, then in the result register. A
// new sample can be taken every cycle while the output is not stalled; the stage state
// is updated from the registered sample, and that loop sets the one-sample-per-cycle
// rate. Configuration writes take effect on the next edge and must be made while idle.
// depends on dsts_pkg, dsts_regs, dsts_fsm
module drag_start_tree_sequencer_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [2:0]                           i_cfg_idx,
    input  logic [15:0]                          i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // now_ms[31:0], has_fix[32], speed_tenths[44:33], select_held[45],
    // side_button_held[46], button_pressed[47], timer_staged[48], run_active[49],
    // run_total[65:50], start_session[66], zero fill
    input  logic [dsts_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // stage[3:0], exit_session[4], consumed_button[5], green_pulse[6],
    // run_start_pulse[7], countdown[9:8], foul[10], strip_active[11], zero fill
    output logic [dsts_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import dsts_pkg::*;

    t_cfg        cfg;
    t_item       r_in_item;
    logic        r_in_valid;
    logic        r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    t_res        res;
    logic        adv_out;
    logic        proc;

    assign adv_out       = !r_out_valid || m_axis_tready;
    assign proc          = r_in_valid && adv_out;
    assign s_axis_tready = !r_in_valid || adv_out;

    dsts_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    dsts_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (proc),
        .i_item  (r_in_item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item.now_ms           <= s_axis_tdata[31:0];
            r_in_item.has_fix          <= s_axis_tdata[32];
            r_in_item.speed_tenths     <= s_axis_tdata[44:33];
            r_in_item.select_held      <= s_axis_tdata[45];
            r_in_item.side_button_held <= s_axis_tdata[46];
            r_in_item.button_pressed   <= s_axis_tdata[47];
            r_in_item.timer_staged     <= s_axis_tdata[48];
            r_in_item.run_active       <= s_axis_tdata[49];
            r_in_item.run_total        <= s_axis_tdata[65:50];
            r_in_item.start_session    <= s_axis_tdata[66];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out_data <= {4'd0, res.strip_active, res.foul, res.countdown,
                           res.run_start_pulse, res.green_pulse, res.consumed_button,
                           res.exit_session, res.stage};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ verif/drag_start_tree_sequencer_core_test.sv @@
// self-checking testbench for drag_start_tree_sequencer_core: streams sample words,
// predicts every result word with its own stage model and compares it field by field
// depends on dsts_pkg and the drag_start_tree_sequencer_core rtl
module drag_start_tree_sequencer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dsts_pkg::*;

    localparam int         SETTLE_CYCLES = 6;
    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         MAX_REPORTS   = 100;
    localparam logic [2:0] CFG_SPARE_A   = 3'd6;
    localparam logic [2:0] CFG_SPARE_B   = 3'd7;

    typedef enum logic [3:0] {
        STG_AWAIT_ARM, STG_WAIT_STOP, STG_PRESTAGE, STG_YELLOW1, STG_YELLOW2, STG_YELLOW3,
        STG_GREEN, STG_RUNNING, STG_RESULTS, STG_RED_LIGHT, STG_FAILED_LAUNCH, STG_ABORTED
    } t_stage;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_SPARSE} t_rx_pace;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [2:0]             i_cfg_idx = '0;
    logic [15:0]            i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // shadow of the configuration registers
    logic [15:0] hold_exit_limit = 16'd2000;
    logic [15:0] prestage_limit  = 16'd500;
    logic [15:0] step_limit      = 16'd500;
    logic [15:0] no_launch_limit = 16'd3000;
    logic [15:0] no_run_limit    = 16'd2000;
    logic [11:0] moving_speed    = 12'd10;

    // predicted sequencer state
    t_stage      stage_now       = STG_AWAIT_ARM;
    logic [31:0] stage_since_ms  = '0;
    logic [31:0] green_at_ms     = '0;
    logic [31:0] hold_from_ms    = '0;
    logic        hold_armed      = 1'b0;
    logic        select_released = 1'b0;
    logic        run_seen        = 1'b0;
    logic [15:0] runs_at_launch  = '0;
    t_res        tree_results_due[$];

    // stimulus scene
    logic [31:0] scene_ms   = '0;
    logic [15:0] scene_runs = '0;
    logic        scene_run  = 1'b0;
    int          select_hold_left;
    int          step_ms_max = 250;
    int          burst_left;
    bit          steady_sender;

    int          hold_off_req;
    int          hold_off_left;
    int          rx_ticks;
    t_rx_pace    rx_mode = RX_OPEN;
    int          mismatch_count;
    int          cycle_count;
    t_res        want;

    drag_start_tree_sequencer_core DUT (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void enter_stage(input t_stage st, input logic [31:0] at_ms);
        stage_now      = st;
        stage_since_ms = at_ms;
    endfunction

    function automatic t_res advance_tree(input t_item s);
        t_res r;
        logic moving;
        r = '0;
        if (s.start_session) begin
            stage_now       = STG_AWAIT_ARM;
            stage_since_ms  = s.now_ms;
            green_at_ms     = '0;
            hold_from_ms    = '0;
            hold_armed      = 1'b0;
            select_released = 1'b0;
            run_seen        = 1'b0;
            runs_at_launch  = '0;
        end
        moving = s.has_fix && (s.speed_tenths >= moving_speed);

        if (!s.select_held)
            select_released = 1'b1;
        if (stage_now != STG_RUNNING && select_released && s.select_held
                && !s.side_button_held) begin
            if (!hold_armed) begin
                hold_armed   = 1'b1;
                hold_from_ms = s.now_ms;
            end else if (s.now_ms - hold_from_ms >= hold_exit_limit) begin
                r.exit_session = 1'b1;
            end
        end else begin
            hold_armed = 1'b0;
        end

        if (!r.exit_session) begin
            case (stage_now)
                STG_AWAIT_ARM: begin
                    if (s.button_pressed) begin
                        r.consumed_button = 1'b1;
                        enter_stage(STG_WAIT_STOP, s.now_ms);
                    end
                end
                STG_WAIT_STOP: begin
                    if (s.timer_staged)
                        enter_stage(STG_PRESTAGE, s.now_ms);
                end
                STG_PRESTAGE: begin
                    if (!s.timer_staged)
                        enter_stage(STG_WAIT_STOP, s.now_ms);
                    else if (s.now_ms - stage_since_ms >= prestage_limit)
                        enter_stage(STG_YELLOW1, s.now_ms);
                end
                STG_YELLOW1, STG_YELLOW2, STG_YELLOW3: begin
                    if (moving) begin
                        enter_stage(STG_RED_LIGHT, s.now_ms);
                    end else if (!s.timer_staged || !s.has_fix) begin
                        enter_stage(STG_WAIT_STOP, s.now_ms);
                    end else if (s.now_ms - stage_since_ms >= step_limit) begin
                        enter_stage(t_stage'(stage_now + 4'd1), s.now_ms);
                        if (stage_now == STG_GREEN) begin
                            green_at_ms   = s.now_ms;
                            r.green_pulse = 1'b1;
                        end
                    end
                end
                STG_GREEN: begin
                    if (s.run_active && !run_seen) begin
                        r.run_start_pulse = 1'b1;
                        runs_at_launch    = s.run_total;
                        enter_stage(STG_RUNNING, s.now_ms);
                    end else if (!moving && s.now_ms - green_at_ms >= no_launch_limit) begin
                        enter_stage(STG_FAILED_LAUNCH, s.now_ms);
                    end else if (moving && !s.run_active
                            && s.now_ms - green_at_ms >= no_run_limit) begin
                        enter_stage(STG_ABORTED, s.now_ms);
                    end
                end
                STG_RUNNING: begin
                    if (s.run_total > runs_at_launch)
                        enter_stage(STG_RESULTS, s.now_ms);
                    else if (!s.run_active && run_seen)
                        enter_stage(STG_ABORTED, s.now_ms);
                end
                STG_RESULTS, STG_RED_LIGHT, STG_FAILED_LAUNCH, STG_ABORTED: begin
                    if (s.button_pressed) begin
                        r.consumed_button = 1'b1;
                        enter_stage(STG_WAIT_STOP, s.now_ms);
                    end
                end
                default: ;
            endcase
        end
        run_seen = s.run_active;

        r.stage = stage_now;
        case (stage_now)
            STG_YELLOW1: r.countdown = CD_YELLOW1;
            STG_YELLOW2: r.countdown = CD_YELLOW2;
            STG_YELLOW3: r.countdown = CD_YELLOW3;
            default:     r.countdown = CD_NONE;
        endcase
        r.foul = (stage_now == STG_RED_LIGHT || stage_now == STG_FAILED_LAUNCH
                  || stage_now == STG_ABORTED);
        r.strip_active = (stage_now != STG_RUNNING);
        return r;
    endfunction

    function automatic t_item tree_input(input logic [31:0] now_ms, input int fix,
                                         input int speed, input int sel,
                                         input int side, input int press,
                                         input int staged, input int run,
                                         input logic [15:0] runs, input int start);
        t_item s;
        s.now_ms           = now_ms;
        s.has_fix          = 1'(fix);
        s.speed_tenths     = 12'(speed);
        s.select_held      = 1'(sel);
        s.side_button_held = 1'(side);
        s.button_pressed   = 1'(press);
        s.timer_staged     = 1'(staged);
        s.run_active       = 1'(run);
        s.run_total        = runs;
        s.start_session    = 1'(start);
        return s;
    endfunction

    // sample steered by the predicted stage so that sessions get deep into the tree
    function automatic t_item next_tree_sample();
        t_item s;
        int    moving_pct;
        int    staged_pct;
        int    press_pct;
        moving_pct = 10;
        staged_pct = 50;
        press_pct  = 8;
        case (stage_now)
            STG_AWAIT_ARM: begin
                staged_pct = 30;
                press_pct  = 40;
            end
            STG_PRESTAGE: staged_pct = 92;
            STG_YELLOW1, STG_YELLOW2, STG_YELLOW3: begin
                moving_pct = 3;
                staged_pct = 98;
            end
            STG_GREEN: moving_pct = 50;
            STG_RUNNING: begin
                moving_pct = 80;
                staged_pct = 20;
            end
            STG_RESULTS, STG_RED_LIGHT, STG_FAILED_LAUNCH, STG_ABORTED: begin
                moving_pct = 30;
                staged_pct = 30;
                press_pct  = 40;
            end
            default: ;
        endcase

        scene_ms += ($urandom_range(0, 49) == 0) ? $urandom : $urandom_range(0, step_ms_max);
        s.now_ms  = scene_ms;
        s.has_fix = ($urandom_range(0, 39) != 0);
        if (moving_speed == 0 || $urandom_range(0, 99) < moving_pct)
            s.speed_tenths = 12'($urandom_range(moving_speed, 4095));
        else
            s.speed_tenths = 12'($urandom_range(0, moving_speed - 1));

        if (select_hold_left == 0 && $urandom_range(0, 29) == 0)
            select_hold_left = $urandom_range(2, 24);
        s.select_held = (select_hold_left != 0);
        if (select_hold_left != 0)
            select_hold_left--;
        s.side_button_held = ($urandom_range(0, 24) == 0);
        s.button_pressed   = ($urandom_range(0, 99) < press_pct);
        s.timer_staged     = ($urandom_range(0, 99) < staged_pct);

        case (stage_now)
            STG_GREEN:   if ($urandom_range(0, 3) == 0) scene_run = ~scene_run;
            STG_RUNNING: if ($urandom_range(0, 24) == 0) scene_run = 1'b0;
            default:     if ($urandom_range(0, 9) == 0) scene_run = ~scene_run;
        endcase
        s.run_active = scene_run;
        if (stage_now == STG_RUNNING && $urandom_range(0, 6) == 0)
            scene_runs++;
        else if ($urandom_range(0, 49) == 0)
            scene_runs = 16'($urandom);
        s.run_total     = scene_runs;
        s.start_session = ($urandom_range(0, 99) == 0);
        return s;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic send_sample(input t_item s);
        int gap;
        if (burst_left == 0) begin
            gap = steady_sender ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
            burst_left = $urandom_range(1, 16);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, s.start_session, s.run_total, s.run_active, s.timer_staged,
                          s.button_pressed, s.side_button_held, s.select_held,
                          s.speed_tenths, s.has_fix, s.now_ms};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tree_results_due.push_back(advance_tree(s));
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (tree_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_register(input logic [2:0] idx, input logic [15:0] value);
        wait_for_drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_EXIT_HOLD:   hold_exit_limit = value;
            CFG_PRESTAGE:    prestage_limit  = value;
            CFG_TREE_STEP:   step_limit      = value;
            CFG_FAILED:      no_launch_limit = value;
            CFG_GREEN_NORUN: no_run_limit    = value;
            CFG_LAUNCH_SPD:  moving_speed    = value[11:0];
            default: ;
        endcase
    endtask

    task automatic load_tree_timing(input logic [15:0] exit_ms, input logic [15:0] pre_ms,
                                    input logic [15:0] step_ms, input logic [15:0] fail_ms,
                                    input logic [15:0] norun_ms, input logic [11:0] speed);
        set_register(CFG_EXIT_HOLD, exit_ms);
        set_register(CFG_PRESTAGE, pre_ms);
        set_register(CFG_TREE_STEP, step_ms);
        set_register(CFG_FAILED, fail_ms);
        set_register(CFG_GREEN_NORUN, norun_ms);
        set_register(CFG_LAUNCH_SPD, {4'b0, speed});
    endtask

    task automatic run_sessions(input int n_items);
        t_item s;
        int    sent;
        int    span;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0)
                scene_ms = 32'hFFFF_FFFF - $urandom_range(0, 20 * step_ms_max);
            span = $urandom_range(20, 80);
            for (int k = 0; k < span && sent < n_items; k++) begin
                s = next_tree_sample();
                if (k == 0)
                    s.start_session = 1'b1;
                send_sample(s);
                sent++;
            end
        end
    endtask

    task automatic test_directed();
        logic [31:0] t0;
        t0 = 32'hFFFF_FF00;
        send_sample(tree_input(t0,         1, 0,    0, 0, 0, 0, 0, 16'h0000, 1));
        send_sample(tree_input(t0 + 1,     1, 0,    0, 0, 1, 0, 0, 16'h0000, 0));
        send_sample(tree_input(t0 + 2,     1, 5,    0, 0, 0, 1, 0, 16'h0000, 0));
        send_sample(tree_input(t0 + 3,     1, 5,    0, 0, 0, 0, 0, 16'h0000, 0));
        send_sample(tree_input(t0 + 4,     1, 0,    0, 0, 0, 1, 0, 16'h0000, 0));
        send_sample(tree_input(t0 + 504,   1, 9,    0, 0, 0, 1, 0, 16'h0000, 0));
        send_sample(tree_input(t0 + 1004,  1, 0,    0, 0, 0, 1, 0, 16'h0000, 0));
        send_sample(tree_input(t0 + 1504,  1, 0,    0, 0, 0, 1, 0, 16'h0000, 0));
        send_sample(tree_input(t0 + 2004,  1, 0,    0, 0, 0, 1, 0, 16'h0000, 0));
        send_sample(tree_input(t0 + 2100,  1, 4095, 0, 0, 0, 0, 1, 16'h0000, 0));
        send_sample(tree_input(t0 + 2200,  1, 4095, 0, 0, 0, 0, 1, 16'hFFFF, 0));
        send_sample(tree_input(t0 + 2300,  1, 0,    0, 0, 1, 1, 0, 16'hFFFF, 0));
        send_sample(tree_input(t0 + 2301,  0, 4095, 0, 0, 0, 1, 0, 16'hFFFF, 0));
        send_sample(tree_input(t0 + 2801,  0, 4095, 0, 0, 0, 1, 0, 16'hFFFF, 0));
        send_sample(tree_input(t0 + 2802,  0, 0,    0, 0, 0, 1, 0, 16'hFFFF, 0));
        send_sample(tree_input(t0 + 2803,  1, 0,    0, 0, 0, 1, 0, 16'hFFFF, 0));
        send_sample(tree_input(t0 + 3303,  1, 0,    0, 0, 0, 1, 0, 16'hFFFF, 0));
        send_sample(tree_input(t0 + 3304,  1, 4095, 0, 0, 0, 1, 0, 16'hFFFF, 0));
        send_sample(tree_input(t0 + 3400,  1, 0,    1, 0, 0, 0, 0, 16'hFFFF, 0));
        send_sample(tree_input(t0 + 3500,  1, 0,    1, 1, 0, 0, 0, 16'hFFFF, 0));
        send_sample(tree_input(t0 + 3600,  1, 0,    1, 0, 0, 0, 0, 16'hFFFF, 0));
        send_sample(tree_input(t0 + 5600,  1, 0,    1, 0, 1, 0, 0, 16'hFFFF, 0));
        send_sample(tree_input(32'hFFFF_FFFF, 1, 0, 1, 0, 0, 0, 0, 16'hFFFF, 0));
        send_sample(tree_input(32'h0,      0, 0,    0, 0, 1, 0, 0, 16'h0000, 0));
        send_sample(tree_input(32'h0,      0, 0,    0, 0, 0, 0, 0, 16'h0000, 1));
    endtask

    task automatic test_default_sessions();
        step_ms_max = 250;
        run_sessions(260);
    endtask

    task automatic test_zero_settings();
        load_tree_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 12'd4095);
        set_register(CFG_SPARE_A, 16'($urandom));
        set_register(CFG_SPARE_B, 16'hFFFF);
        step_ms_max = 3;
        run_sessions(60);
        set_register(CFG_LAUNCH_SPD, 16'd0);
        run_sessions(50);
    endtask

    task automatic test_max_settings();
        load_tree_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF);
        step_ms_max = 30000;
        run_sessions(100);
    endtask

    task automatic test_random_settings();
        repeat (3) begin
            load_tree_timing(16'($urandom_range(0, 600)), 16'($urandom_range(0, 600)),
                             16'($urandom_range(0, 600)), 16'($urandom_range(0, 600)),
                             16'($urandom_range(0, 600)), 12'($urandom_range(0, 400)));
            set_register(CFG_SPARE_A, 16'($urandom));
            step_ms_max = $urandom_range(10, 300);
            run_sessions(70);
        end
    endtask

    // output held off while the sender keeps pushing, so the input side backs up
    task automatic test_output_backpressure();
        load_tree_timing(16'd2000, 16'd500, 16'd500, 16'd3000, 16'd2000, 12'd10);
        step_ms_max   = 250;
        hold_off_req  = 400;
        steady_sender = 1'b1;
        run_sessions(60);
        steady_sender = 1'b0;
    endtask

    task automatic test_random_noise();
        t_item s;
        repeat (80) begin
            s.now_ms           = $urandom;
            s.has_fix          = 1'($urandom_range(0, 1));
            s.speed_tenths     = 12'($urandom_range(0, 4095));
            s.select_held      = 1'($urandom_range(0, 1));
            s.side_button_held = 1'($urandom_range(0, 1));
            s.button_pressed   = 1'($urandom_range(0, 1));
            s.timer_staged     = 1'($urandom_range(0, 1));
            s.run_active       = 1'($urandom_range(0, 1));
            s.run_total        = 16'($urandom_range(0, 65535));
            s.start_session    = ($urandom_range(0, 15) == 0);
            send_sample(s);
        end
    endtask

    always @(posedge i_clk) begin
        rx_ticks++;
        if (rx_ticks % 97 == 0)
            rx_mode = t_rx_pace'($urandom_range(0, 3));
        if (hold_off_req != 0) begin
            hold_off_left = hold_off_req;
            hold_off_req  = 0;
        end
        if (hold_off_left != 0) begin
            hold_off_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:    m_axis_tready <= 1'b1;
                RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: m_axis_tready <= (rx_ticks % 5 < 3);
                default:    m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (tree_results_due.size() == 0) begin
                report_mismatch($sformatf("result word %h with nothing expected",
                                          m_axis_tdata));
            end else begin
                want = tree_results_due.pop_front();
                if (m_axis_tdata[3:0] !== want.stage)
                    report_mismatch($sformatf("stage %0d expected %0d",
                                              m_axis_tdata[3:0], want.stage));
                if (m_axis_tdata[4] !== want.exit_session)
                    report_mismatch($sformatf("exit_session %b expected %b",
                                              m_axis_tdata[4], want.exit_session));
                if (m_axis_tdata[5] !== want.consumed_button)
                    report_mismatch($sformatf("consumed_button %b expected %b",
                                              m_axis_tdata[5], want.consumed_button));
                if (m_axis_tdata[6] !== want.green_pulse)
                    report_mismatch($sformatf("green_pulse %b expected %b",
                                              m_axis_tdata[6], want.green_pulse));
                if (m_axis_tdata[7] !== want.run_start_pulse)
                    report_mismatch($sformatf("run_start_pulse %b expected %b",
                                              m_axis_tdata[7], want.run_start_pulse));
                if (m_axis_tdata[9:8] !== want.countdown)
                    report_mismatch($sformatf("countdown %0d expected %0d",
                                              m_axis_tdata[9:8], want.countdown));
                if (m_axis_tdata[10] !== want.foul)
                    report_mismatch($sformatf("foul %b expected %b",
                                              m_axis_tdata[10], want.foul));
                if (m_axis_tdata[11] !== want.strip_active)
                    report_mismatch($sformatf("strip_active %b expected %b",
                                              m_axis_tdata[11], want.strip_active));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("drag_start_tree_sequencer_core_test NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        scene_ms   = $urandom;
        scene_runs = 16'($urandom);
        test_directed();
        test_default_sessions();
        test_zero_settings();
        test_max_settings();
        test_random_settings();
        test_output_backpressure();
        test_random_noise();
        wait_for_drain();
        if (mismatch_count == 0)
            $display("drag_start_tree_sequencer_core_test OK");
        else
            $display("drag_start_tree_sequencer_core_test NOT OK");
        $finish;
    end

endmodule
